@@ hw/rtl/exponential_range_packer_unit_macros.svh @@
// Assertion helpers for the range packer.
`ifndef EXPONENTIAL_RANGE_PACKER_UNIT_MACROS_SVH
`define EXPONENTIAL_RANGE_PACKER_UNIT_MACROS_SVH

// same-cycle implication
`define ERP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ERP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/erp_pkg.sv @@
package erp_pkg;

    localparam int unsigned ERP_WORD_BITS = 32;
    localparam int unsigned ERP_CELLS     = 64;

    typedef enum logic [1:0] {
        CFG_MIN_VALUE    = 2'd0,
        CFG_VALUE_RANGE  = 2'd1,
        CFG_MAX_EXPONENT = 2'd2,
        CFG_TOTAL_BITS   = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_UP   = 2'd1;
    localparam logic [1:0] ST_DOWN = 2'd2;

    // configuration with the derived quantities worked out once
    typedef struct packed {
        logic [31:0] min_value;
        logic [31:0] range_eff;
        logic [31:0] maxnorm;
        logic [4:0]  max_exp;
        logic [2:0]  eb;
        logic [5:0]  mb;
        logic [31:0] exp_mask;
        logic [31:0] man_mask;
    } erp_cfg_t;

    // one request as it travels the divider chain
    typedef struct packed {
        logic        valid;
        logic        unpack;
        logic        below;
        logic        sat;
        logic        ovf;
        logic [31:0] rem;
        logic [63:0] quo;
        logic [63:0] dvd;
    } erp_lane_t;

    function automatic logic [2:0] bit_len5(input logic [4:0] x);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < 5; i++) begin
            if (x[i]) begin
                n = 3'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/erp_front.sv @@
module erp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic               in_unpack,
    input  logic signed [31:0] sample_value,
    input  logic [31:0]        packed_word,
    input  erp_pkg::erp_cfg_t  cfg,
    output erp_pkg::erp_lane_t lane_out
);
    import erp_pkg::*;

    // stage 1: offset from range start, unpack cell midpoint
    logic        s1_valid_reg, s1_unpack_reg, s1_below_reg;
    logic [31:0] s1_diff_reg;
    logic [64:0] s1_t_reg;
    logic [32:0] diff_next;
    logic [4:0]  iexp;
    logic [31:0] iman;
    logic [33:0] a_mid;
    logic [64:0] t_next;

    always_comb begin
        diff_next = {sample_value[31], sample_value} - {cfg.min_value[31], cfg.min_value};
        iexp      = packed_word[4:0] & cfg.exp_mask[4:0];
        iman      = (packed_word >> cfg.eb) & cfg.man_mask;
        a_mid     = (34'd1 << ({1'b0, cfg.mb} + 7'd1)) + {1'b0, iman, 1'b1};
        t_next    = ({31'b0, a_mid} << iexp) - (65'd1 << ({1'b0, cfg.mb} + 7'd1));
    end

    // stage 2: products
    logic        s2_valid_reg, s2_unpack_reg, s2_below_reg;
    logic [63:0] s2_prod_lo_reg;
    logic [64:0] s2_prod_hi_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_lo_next;
    logic [64:0] prod_hi_next;

    always_comb begin
        mul_a        = s1_unpack_reg ? s1_t_reg[31:0] : s1_diff_reg;
        mul_b        = s1_unpack_reg ? cfg.range_eff : cfg.maxnorm;
        prod_lo_next = mul_a * mul_b;
        prod_hi_next = s1_t_reg[64:32] * cfg.range_eff;
    end

    // stage 3: pack renorm numerator, or full unpack product
    logic        s3_valid_reg, s3_unpack_reg, s3_below_reg;
    logic [96:0] s3_sum_reg;
    logic [96:0] sum_next;

    always_comb begin
        sum_next = (s2_unpack_reg ? {s2_prod_hi_reg, 32'b0} : {65'b0, cfg.range_eff})
                   + {33'b0, s2_prod_lo_reg};
    end

    // stage 4: saturation test for pack, rounding offset for unpack
    logic        s4_valid_reg, s4_unpack_reg, s4_below_reg, s4_sat_reg;
    logic [97:0] s4_acc_reg;
    logic [63:0] sat_lim;
    logic        sat_next;
    logic [97:0] acc_next;

    always_comb begin
        sat_lim  = {32'b0, cfg.range_eff} << ({1'b0, cfg.max_exp} + 6'd1);
        sat_next = !s3_unpack_reg && (s3_sum_reg[63:0] >= sat_lim);
        if (s3_unpack_reg) begin
            acc_next = {1'b0, s3_sum_reg} + {34'b0, ({32'b0, cfg.maxnorm} << cfg.mb)};
        end else begin
            acc_next = {2'b0, s3_sum_reg[63:0], 32'b0};
        end
    end

    // stage 5: unpack drops the cell fraction bits
    logic        s5_valid_reg, s5_unpack_reg, s5_below_reg, s5_sat_reg;
    logic [97:0] s5_dvd_reg;
    logic [97:0] dvd_next;

    always_comb begin
        dvd_next = s4_unpack_reg ? (s4_acc_reg >> ({1'b0, cfg.mb} + 7'd1)) : s4_acc_reg;
    end

    // stage 6: quotient overflow check and chain entry
    logic      lane_valid_reg;
    erp_lane_t lane_reg, lane_next;

    always_comb begin
        lane_next        = '0;
        lane_next.unpack = s5_unpack_reg;
        lane_next.below  = s5_below_reg;
        lane_next.sat    = s5_sat_reg;
        lane_next.ovf    = s5_unpack_reg && (s5_dvd_reg[97:34] >= {32'b0, cfg.maxnorm});
        lane_next.rem    = s5_dvd_reg[95:64];
        lane_next.dvd    = s5_dvd_reg[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            lane_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            s5_valid_reg   <= s4_valid_reg;
            lane_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_unpack_reg  <= in_unpack;
            s1_below_reg   <= diff_next[32];
            s1_diff_reg    <= diff_next[31:0];
            s1_t_reg       <= t_next;
            s2_unpack_reg  <= s1_unpack_reg;
            s2_below_reg   <= s1_below_reg;
            s2_prod_lo_reg <= prod_lo_next;
            s2_prod_hi_reg <= prod_hi_next;
            s3_unpack_reg  <= s2_unpack_reg;
            s3_below_reg   <= s2_below_reg;
            s3_sum_reg     <= sum_next;
            s4_unpack_reg  <= s3_unpack_reg;
            s4_below_reg   <= s3_below_reg;
            s4_sat_reg     <= sat_next;
            s4_acc_reg     <= acc_next;
            s5_unpack_reg  <= s4_unpack_reg;
            s5_below_reg   <= s4_below_reg;
            s5_sat_reg     <= s4_sat_reg;
            s5_dvd_reg     <= dvd_next;
            lane_reg       <= lane_next;
        end
    end

    always_comb begin
        lane_out       = lane_reg;
        lane_out.valid = lane_valid_reg;
    end

endmodule

@@ hw/rtl/erp_cell.sv @@
module erp_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  erp_pkg::erp_lane_t lane_in,
    input  erp_pkg::erp_cfg_t  cfg,
    output erp_pkg::erp_lane_t lane_out
);
    import erp_pkg::*;

    // one restoring division step: one dividend bit in, one quotient bit out
    logic      valid_reg;
    erp_lane_t lane_reg, lane_next;
    logic [31:0] divisor;
    logic [32:0] trial, trial_sub;
    logic        take;

    always_comb begin
        divisor   = lane_in.unpack ? cfg.maxnorm : cfg.range_eff;
        trial     = {lane_in.rem, lane_in.dvd[63]};
        trial_sub = trial - {1'b0, divisor};
        take      = trial >= {1'b0, divisor};
        lane_next     = lane_in;
        lane_next.rem = take ? trial_sub[31:0] : trial[31:0];
        lane_next.quo = {lane_in.quo[62:0], take};
        lane_next.dvd = {lane_in.dvd[62:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= lane_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    always_comb begin
        lane_out       = lane_reg;
        lane_out.valid = valid_reg;
    end

endmodule

@@ hw/rtl/erp_back.sv @@
module erp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  erp_pkg::erp_lane_t lane_in,
    input  erp_pkg::erp_cfg_t  cfg,
    output logic               out_valid,
    output logic [31:0]        packed_result,
    output logic signed [31:0] value_result,
    output logic [1:0]         status
);
    import erp_pkg::*;

    // stage 1: exponent from the quotient's leading one, unpack value
    logic        e1_valid_reg, e1_unpack_reg, e1_below_reg, e1_sat_reg;
    logic [4:0]  e1_k_reg;
    logic [63:0] e1_quo_reg;
    logic [31:0] e1_val_reg;
    logic [4:0]  k_next;
    logic [33:0] rq;
    logic [35:0] sum36;
    logic        vsat;
    logic [31:0] val_next;

    always_comb begin
        k_next = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (lane_in.quo[32 + i]) begin
                k_next = 5'(i);
            end
        end
        rq    = lane_in.quo[33:0];
        sum36 = {{4{cfg.min_value[31]}}, cfg.min_value} + {2'b0, rq};
        // sum can't go below the 32-bit minimum, only above the maximum
        vsat  = lane_in.ovf || (rq > 34'h2_0000_0000)
                || (!sum36[35] && (sum36[34:31] != 4'd0));
        val_next = vsat ? 32'h7FFF_FFFF : sum36[31:0];
    end

    // stage 2: mantissa extraction and word assembly
    logic        out_valid_reg;
    logic [31:0] packed_reg, value_reg;
    logic [1:0]  status_reg;
    logic [6:0]  sh;
    logic [63:0] shifted;
    logic [31:0] man;
    logic [31:0] packed_next, value_next;
    logic [1:0]  status_next;

    always_comb begin
        sh      = 7'd32 + {2'b0, e1_k_reg} - {1'b0, cfg.mb};
        shifted = e1_quo_reg >> sh;
        man     = shifted[31:0] & cfg.man_mask;
        packed_next = 32'd0;
        value_next  = 32'd0;
        status_next = ST_OK;
        if (e1_unpack_reg) begin
            value_next = e1_val_reg;
        end else if (e1_below_reg) begin
            status_next = ST_UP;
        end else if (e1_sat_reg) begin
            packed_next = ({27'b0, cfg.max_exp} & cfg.exp_mask) | (cfg.man_mask << cfg.eb);
            status_next = ST_DOWN;
        end else begin
            packed_next = ({27'b0, e1_k_reg} & cfg.exp_mask) | (man << cfg.eb);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            e1_valid_reg  <= lane_in.valid;
            out_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_unpack_reg <= lane_in.unpack;
            e1_below_reg  <= lane_in.below;
            e1_sat_reg    <= lane_in.sat;
            e1_k_reg      <= k_next;
            e1_quo_reg    <= lane_in.quo;
            e1_val_reg    <= val_next;
            packed_reg    <= packed_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packed_result = packed_reg;
    assign value_result  = value_reg;
    assign status        = status_reg;

endmodule

@@ hw/rtl/exponential_range_packer_unit.sv @@
// Range packer: turns a signed value into an exponent/mantissa word, or back.
// Request channel s_*: s_req_type 0 packs s_sample_value, 1 unpacks
// s_packed_word. Result channel m_*: packed word, rebuilt value, status
// (0 ok, 1 clamped up below range, 2 clamped down above range).
// Configuration is written through cfg_we/cfg_idx/cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. A request
// passes through 72 register stages: six set-up stages (offset, multiply,
// add, range test, shift, entry), a chain of 64 restoring-divider cells that
// each settle one quotient bit, and two finishing stages, the last being the
// output register. Throughput: one request per cycle unless the pipe holds;
// the chain is fully pipelined. When m_ready is low with a result showing,
// the whole pipe holds and s_ready drops; it rises again the cycle the
// result is taken. Reset clears all valid bits and loads the registers with
// min 0, range 65535, max exponent 7, word width 16.
`include "exponential_range_packer_unit_macros.svh"

module exponential_range_packer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic signed [31:0] s_sample_value,
    input  logic [31:0]        s_packed_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_packed_result,
    output logic signed [31:0] m_value_result,
    output logic [1:0]         m_status
);
    import erp_pkg::*;

    logic [31:0] min_value_reg;
    logic [31:0] value_range_reg;
    logic [4:0]  max_exp_reg;
    logic [5:0]  total_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg   <= 32'd0;
            value_range_reg <= 32'd65535;
            max_exp_reg     <= 5'd7;
            total_bits_reg  <= 6'd16;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_MIN_VALUE:    min_value_reg   <= cfg_wdata;
                CFG_VALUE_RANGE:  value_range_reg <= cfg_wdata;
                CFG_MAX_EXPONENT: max_exp_reg     <= cfg_wdata[4:0];
                CFG_TOTAL_BITS:   total_bits_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    erp_cfg_t    cfg;
    logic [5:0]  nb;
    logic [32:0] maxnorm_w, man_mask_w;
    logic [5:0]  exp_mask_w;

    always_comb begin
        cfg.min_value = min_value_reg;
        cfg.range_eff = (value_range_reg == 32'd0) ? 32'd1 : value_range_reg;
        cfg.max_exp   = max_exp_reg;
        cfg.eb        = bit_len5(max_exp_reg);
        nb            = (total_bits_reg > 6'(ERP_WORD_BITS)) ? 6'(ERP_WORD_BITS)
                                                             : total_bits_reg;
        cfg.mb        = (nb > {3'b0, cfg.eb}) ? nb - {3'b0, cfg.eb} : 6'd0;
        maxnorm_w     = (33'd1 << ({1'b0, max_exp_reg} + 6'd1)) - 33'd1;
        cfg.maxnorm   = maxnorm_w[31:0];
        exp_mask_w    = (6'd1 << cfg.eb) - 6'd1;
        cfg.exp_mask  = {26'b0, exp_mask_w};
        man_mask_w    = (33'd1 << cfg.mb) - 33'd1;
        cfg.man_mask  = man_mask_w[31:0];
    end

    // whole pipe moves together; the output register frees it when taken
    logic pipe_en;
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    erp_lane_t        lane [ERP_CELLS + 1];
    logic [ERP_CELLS:0] lane_valid;

    erp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (pipe_en),
        .in_valid     (s_valid),
        .in_unpack    (s_req_type),
        .sample_value (s_sample_value),
        .packed_word  (s_packed_word),
        .cfg          (cfg),
        .lane_out     (lane[0])
    );

    for (genvar g = 0; g < ERP_CELLS; g++) begin : g_cell
        erp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .lane_in  (lane[g]),
            .cfg      (cfg),
            .lane_out (lane[g + 1])
        );
    end

    for (genvar v = 0; v <= ERP_CELLS; v++) begin : g_valid
        assign lane_valid[v] = lane[v].valid;
    end

    erp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (pipe_en),
        .lane_in       (lane[ERP_CELLS]),
        .cfg           (cfg),
        .out_valid     (m_valid),
        .packed_result (m_packed_result),
        .value_result  (m_value_result),
        .status        (m_status)
    );

    `ERP_ASSERT_NXT(a_chain_holds, aclk, aresetn, !pipe_en, $stable(lane_valid), "divider chain moved while stalled")
    `ERP_ASSERT_IMP(a_status_pack_only, aclk, aresetn, m_valid && (m_status != ST_OK), m_value_result == 32'sd0, "clamp status on an unpack result")
    `ERP_ASSERT_IMP(a_below_zero_word, aclk, aresetn, m_valid && (m_status == ST_UP), m_packed_result == 32'd0, "below-range pack gave a nonzero word")

endmodule
